// ===== rtl/smim_pkg.sv =====
// Shared types and constants for the SPI mode 3 sensor register master.
// Holds the beat structs of both channels and the command codes; no dependencies.
package smim_pkg;

  localparam int unsigned ADDR_W      = 7;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned AXIS_W      = 16;
  localparam int unsigned NUM_AXES    = 6;
  localparam int unsigned BYTE_IDX_W  = 4;
  localparam int unsigned BIT_IDX_W   = 3;
  localparam int unsigned AXIS_IDX_W  = 3;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_BURST = 2'd3;

  localparam logic [ADDR_W-1:0]     BURST_ADDR_RST = 7'd34;
  localparam logic [BYTE_IDX_W-1:0] BURST_TOTAL    = 4'd13;
  localparam logic [BYTE_IDX_W-1:0] REG_TOTAL      = 4'd2;
  localparam logic [BIT_IDX_W-1:0]  LAST_BIT       = 3'd7;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] reg_addr;
    logic [BYTE_W-1:0] write_value;
    logic              miso;
  } in_item_t;

  typedef struct packed {
    logic                     sck;
    logic                     mosi;
    logic                     cs_n;
    logic                     busy_res;
    logic                     done_res;
    logic [BYTE_W-1:0]        read_byte;
    logic signed [AXIS_W-1:0] gyro_x;
    logic signed [AXIS_W-1:0] gyro_y;
    logic signed [AXIS_W-1:0] gyro_z;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
  } out_item_t;

endpackage

// ===== rtl/smim_engine.sv =====
// Transaction engine: link state, shift registers, burst axis store, one tick per fire.
// Depends on smim_pkg.
module smim_engine import smim_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  in_item_t          item,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output out_item_t         result
);

  logic                  active_r, active_nxt;
  logic [1:0]            kind_r, kind_nxt;
  logic                  half_r, half_nxt;
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt;
  logic [BYTE_IDX_W-1:0] byte_r, byte_nxt;
  logic [BYTE_W-1:0]     so_r, so_nxt;
  logic [BYTE_W-1:0]     si_r, si_nxt;
  logic [BYTE_W-1:0]     last_r, last_nxt;
  logic [AXIS_W-1:0]     axis_r [NUM_AXES];
  logic [AXIS_W-1:0]     axis_nxt [NUM_AXES];
  logic [ADDR_W-1:0]     burst_addr_r;

  logic                  act;
  logic [1:0]            knd;
  logic                  hp;
  logic [BIT_IDX_W-1:0]  bi;
  logic [BYTE_IDX_W-1:0] byi;
  logic [BYTE_W-1:0]     so, si, si_sh;
  logic [BYTE_IDX_W-1:0] total, k;
  logic [AXIS_IDX_W-1:0] ax;
  logic                  sck, mosi, cs_n, busy, done;

  always_comb begin
    act = active_r;
    knd = kind_r;
    hp  = half_r;
    bi  = bit_r;
    byi = byte_r;
    so  = so_r;
    si  = si_r;
    if (!active_r && item.op != OP_TICK) begin
      act = 1'b1;
      knd = item.op;
      hp  = 1'b0;
      bi  = '0;
      byi = '0;
      case (item.op)
        OP_WRITE: begin
          so = {1'b0, item.reg_addr};
          si = item.write_value;
        end
        OP_READ: begin
          so = {1'b1, item.reg_addr};
          si = '0;
        end
        default: begin
          so = {1'b1, burst_addr_r};
          si = '0;
        end
      endcase
    end

    total = (knd == OP_BURST) ? BURST_TOTAL : REG_TOTAL;
    si_sh = (byi != '0) ? {si[BYTE_W-2:0], item.miso} : si;
    k     = byi - 1'b1;
    ax    = k[BYTE_IDX_W-1:1];

    active_nxt = act;
    kind_nxt   = knd;
    half_nxt   = hp;
    bit_nxt    = bi;
    byte_nxt   = byi;
    so_nxt     = so;
    si_nxt     = si;
    last_nxt   = last_r;
    for (int i = 0; i < NUM_AXES; i++) axis_nxt[i] = axis_r[i];
    sck  = 1'b1;
    mosi = 1'b0;
    cs_n = 1'b1;
    busy = 1'b0;
    done = 1'b0;

    if (act) begin
      busy = 1'b1;
      if (byi >= total) begin
        done       = 1'b1;
        active_nxt = 1'b0;
        half_nxt   = 1'b0;
        bit_nxt    = '0;
        byte_nxt   = '0;
      end else if (!hp) begin
        sck      = 1'b0;
        cs_n     = 1'b0;
        mosi     = so[BYTE_W-1];
        half_nxt = 1'b1;
      end else begin
        sck      = 1'b1;
        cs_n     = 1'b0;
        mosi     = so[BYTE_W-1];
        si_nxt   = si_sh;
        so_nxt   = {so[BYTE_W-2:0], 1'b0};
        half_nxt = 1'b0;
        if (bi == LAST_BIT) begin
          bit_nxt = '0;
          if (knd == OP_READ) begin
            last_nxt = si_sh;
          end else if (knd == OP_BURST && byi != '0) begin
            for (int i = 0; i < NUM_AXES; i++) begin
              if (ax == AXIS_IDX_W'(i)) begin
                if (k[0]) axis_nxt[i] = {si_sh, axis_r[i][BYTE_W-1:0]};
                else      axis_nxt[i] = {axis_r[i][AXIS_W-1:BYTE_W], si_sh};
              end
            end
          end
          so_nxt   = (byi == '0 && knd == OP_WRITE) ? si_sh : '0;
          si_nxt   = '0;
          byte_nxt = byi + 1'b1;
        end else begin
          bit_nxt = bi + 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.sck       = sck;
    result.mosi      = mosi;
    result.cs_n      = cs_n;
    result.busy_res  = busy;
    result.done_res  = done;
    result.read_byte = last_nxt;
    result.gyro_x    = $signed(axis_nxt[0]);
    result.gyro_y    = $signed(axis_nxt[1]);
    result.gyro_z    = $signed(axis_nxt[2]);
    result.accel_x   = $signed(axis_nxt[3]);
    result.accel_y   = $signed(axis_nxt[4]);
    result.accel_z   = $signed(axis_nxt[5]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      kind_r       <= OP_TICK;
      half_r       <= 1'b0;
      bit_r        <= '0;
      byte_r       <= '0;
      so_r         <= '0;
      si_r         <= '0;
      last_r       <= '0;
      burst_addr_r <= BURST_ADDR_RST;
      for (int i = 0; i < NUM_AXES; i++) axis_r[i] <= '0;
    end else begin
      if (cfg_we) burst_addr_r <= cfg_wdata;
      if (fire) begin
        active_r <= active_nxt;
        kind_r   <= kind_nxt;
        half_r   <= half_nxt;
        bit_r    <= bit_nxt;
        byte_r   <= byte_nxt;
        so_r     <= so_nxt;
        si_r     <= si_nxt;
        last_r   <= last_nxt;
        for (int i = 0; i < NUM_AXES; i++) axis_r[i] <= axis_nxt[i];
      end
    end
  end

endmodule

// ===== rtl/spi_mode3_imu_register_master_core.sv =====
// Top level of the SPI mode 3 sensor register master: input beat register,
// engine, result register. Depends on smim_pkg and smim_engine.
//
//   channel | ports                        | beat
//   --------+------------------------------+------------------------------------
//   input   | in_valid, in_stall, in_data  | one half-bit tick: op, addr, data, miso
//   result  | out_valid, out_stall, out_data | pin levels, busy, done, captured data
//   config  | cfg_we, cfg_wdata            | burst start address, no read-back
//
// One tick per cycle while out_stall does not hold the result register; a beat passes
// from the input beat register through the engine to the result register and out_data; the engine steps once per tick.
// Reset (rst_n low, synchronous) clears the valid bits of both beat registers and all link state;
// the burst start address returns to 34.
// out_stall holds the result register, and with it the input register and in_stall.
module spi_mode3_imu_register_master_core import smim_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      adv, fire;

  assign adv      = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  smim_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_item_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r  <= in_valid;
        in_item_r <= in_data;
      end
      if (adv) begin
        out_vld_r  <= in_vld_r;
        out_item_r <= result;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for spi_mode3_imu_register_master_core: drives half-bit tick beats,
// predicts every result beat from its own link model and scoreboards the outputs.
// Depends on smim_pkg and the core RTL.
module tb_top;
  import smim_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_BEATS = 150;
  localparam int unsigned REPORT_LIMIT = 10;

  localparam int unsigned MISO_RANDOM = 0;
  localparam int unsigned MISO_ONES   = 1;
  localparam int unsigned MISO_ZEROS  = 2;

  localparam int unsigned STALL_NONE     = 0;
  localparam int unsigned STALL_RANDOM   = 1;
  localparam int unsigned STALL_PERIODIC = 2;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  spi_mode3_imu_register_master_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Link model state
  logic              p_active;
  logic [1:0]        p_kind;
  logic              p_half;
  logic [2:0]        p_bit;
  logic [3:0]        p_byte;
  logic [7:0]        p_sout;
  logic [7:0]        p_sin;
  logic [7:0]        p_last;
  logic [15:0]       p_axis [NUM_AXES];
  logic [ADDR_W-1:0] p_burst_addr;

  out_item_t   expected_ticks[$];
  out_item_t   want_beat;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  int unsigned burst_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = STALL_NONE;
  int unsigned stall_run = 0;
  logic [2:0]  stall_phase = '0;

  function automatic void reset_link();
    p_active = 1'b0;
    p_kind = OP_TICK;
    p_half = 1'b0;
    p_bit = '0;
    p_byte = '0;
    p_sout = '0;
    p_sin = '0;
    p_last = '0;
    for (int i = 0; i < NUM_AXES; i++) p_axis[i] = '0;
    p_burst_addr = BURST_ADDR_RST;
  endfunction

  function automatic void capture_byte();
    int unsigned k;
    if (p_kind == OP_READ) begin
      p_last = p_sin;
    end else if (p_kind == OP_BURST && p_byte >= 1) begin
      k = p_byte - 1;
      if (k < 12) begin
        if (k[0]) p_axis[k >> 1][15:8] = p_sin;
        else p_axis[k >> 1][7:0] = p_sin;
      end
    end
  endfunction

  function automatic out_item_t advance_link(in_item_t b);
    out_item_t  r;
    logic [3:0] total;
    r = '0;
    r.sck = 1'b1;
    r.cs_n = 1'b1;
    if (!p_active && b.op != OP_TICK) begin
      p_active = 1'b1;
      p_kind = b.op;
      p_half = 1'b0;
      p_bit = '0;
      p_byte = '0;
      case (b.op)
        OP_WRITE: begin
          p_sout = {1'b0, b.reg_addr};
          p_sin = b.write_value;
        end
        OP_READ: begin
          p_sout = {1'b1, b.reg_addr};
          p_sin = '0;
        end
        default: begin
          p_sout = {1'b1, p_burst_addr};
          p_sin = '0;
        end
      endcase
    end
    if (p_active) begin
      r.busy_res = 1'b1;
      total = (p_kind == OP_BURST) ? BURST_TOTAL : REG_TOTAL;
      if (p_byte >= total) begin
        r.done_res = 1'b1;
        p_active = 1'b0;
        p_half = 1'b0;
        p_bit = '0;
        p_byte = '0;
      end else if (!p_half) begin
        r.sck = 1'b0;
        r.cs_n = 1'b0;
        r.mosi = p_sout[7];
        p_half = 1'b1;
      end else begin
        r.sck = 1'b1;
        r.cs_n = 1'b0;
        r.mosi = p_sout[7];
        if (p_byte >= 1) p_sin = {p_sin[6:0], b.miso};
        p_sout = {p_sout[6:0], 1'b0};
        p_half = 1'b0;
        if (p_bit == LAST_BIT) begin
          p_bit = '0;
          capture_byte();
          p_sout = (p_byte == 0 && p_kind == OP_WRITE) ? p_sin : 8'h00;
          p_sin = '0;
          p_byte = p_byte + 4'd1;
        end else begin
          p_bit = p_bit + 3'd1;
        end
      end
    end
    r.read_byte = p_last;
    r.gyro_x = p_axis[0];
    r.gyro_y = p_axis[1];
    r.gyro_z = p_axis[2];
    r.accel_x = p_axis[3];
    r.accel_y = p_axis[4];
    r.accel_z = p_axis[5];
    return r;
  endfunction

  function automatic bit beat_differs(out_item_t a, out_item_t b);
    return (a.sck !== b.sck) || (a.mosi !== b.mosi) || (a.cs_n !== b.cs_n) ||
           (a.busy_res !== b.busy_res) || (a.done_res !== b.done_res) ||
           (a.read_byte !== b.read_byte) || (a.gyro_x !== b.gyro_x) ||
           (a.gyro_y !== b.gyro_y) || (a.gyro_z !== b.gyro_z) ||
           (a.accel_x !== b.accel_x) || (a.accel_y !== b.accel_y) ||
           (a.accel_z !== b.accel_z);
  endfunction

  function automatic in_item_t make_beat(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                         logic [7:0] wval, logic m);
    in_item_t b;
    b.op = op;
    b.reg_addr = addr;
    b.write_value = wval;
    b.miso = m;
    return b;
  endfunction

  function automatic logic pick_miso(int unsigned mode);
    case (mode)
      MISO_ONES:  return 1'b1;
      MISO_ZEROS: return 1'b0;
      default:    return logic'($urandom_range(0, 1));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_beat(in_item_t b);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    expected_ticks.push_back(advance_link(b));
    beats_sent++;
    burst_left--;
  endtask

  // Issue one command, fill the transaction with ignored commands, then idle ticks.
  task automatic run_txn(logic [1:0] op, logic [ADDR_W-1:0] addr, logic [7:0] wval,
                         int unsigned miso_mode, int unsigned idle_after);
    send_beat(make_beat(op, addr, wval, pick_miso(miso_mode)));
    while (p_active)
      send_beat(make_beat(2'($urandom_range(0, 3)), rand_addr(), rand_byte(),
                          pick_miso(miso_mode)));
    repeat (idle_after)
      send_beat(make_beat(OP_TICK, rand_addr(), rand_byte(), pick_miso(MISO_RANDOM)));
  endtask

  task automatic settle();
    while (p_active)
      send_beat(make_beat(OP_TICK, rand_addr(), rand_byte(), pick_miso(MISO_RANDOM)));
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_burst_start(logic [ADDR_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    p_burst_addr = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_idle_ticks();
    send_beat(make_beat(OP_TICK, 7'h7F, 8'hFF, 1'b1));
    send_beat(make_beat(OP_TICK, 7'h00, 8'h00, 1'b0));
    send_beat(make_beat(OP_TICK, rand_addr(), rand_byte(), 1'b1));
    settle();
  endtask

  task automatic test_register_write();
    run_txn(OP_WRITE, 7'h00, 8'hFF, MISO_RANDOM, 0);
    run_txn(OP_WRITE, 7'h7F, 8'h00, MISO_ONES, 1);
    run_txn(OP_WRITE, 7'h55, 8'hA5, MISO_ZEROS, 0);
    settle();
  endtask

  task automatic test_register_read();
    run_txn(OP_READ, 7'h7F, rand_byte(), MISO_ONES, 0);
    run_txn(OP_READ, 7'h00, rand_byte(), MISO_ZEROS, 0);
    run_txn(OP_READ, rand_addr(), rand_byte(), MISO_RANDOM, 2);
    settle();
  endtask

  task automatic test_back_to_back();
    run_txn(OP_READ, rand_addr(), rand_byte(), MISO_RANDOM, 0);
    run_txn(OP_WRITE, rand_addr(), rand_byte(), MISO_RANDOM, 0);
    run_txn(OP_READ, rand_addr(), rand_byte(), MISO_RANDOM, 0);
    settle();
  endtask

  task automatic test_burst_reset_address();
    run_txn(OP_BURST, rand_addr(), rand_byte(), MISO_RANDOM, 1);
    settle();
  endtask

  task automatic test_burst_address_extremes();
    write_burst_start(7'h00);
    run_txn(OP_BURST, rand_addr(), rand_byte(), MISO_ONES, 0);
    settle();
    write_burst_start(7'h7F);
    run_txn(OP_BURST, rand_addr(), rand_byte(), MISO_ZEROS, 0);
    settle();
    write_burst_start(rand_addr());
    run_txn(OP_BURST, rand_addr(), rand_byte(), MISO_RANDOM, 0);
    settle();
  endtask

  task automatic test_input_backpressure();
    hold_req = 80;
    run_txn(OP_READ, rand_addr(), rand_byte(), MISO_RANDOM, 3);
    settle();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned pick;
    logic [1:0]  op;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        settle();
        case ($urandom_range(0, 2))
          0: write_burst_start(7'h00);
          1: write_burst_start(7'h7F);
          default: write_burst_start(rand_addr());
        endcase
      end else if (pick < 18) begin
        repeat ($urandom_range(1, 6))
          send_beat(make_beat(2'($urandom_range(0, 3)), rand_addr(), rand_byte(),
                              pick_miso(MISO_RANDOM)));
      end else begin
        pick = $urandom_range(0, 99);
        op = (pick < 40) ? OP_WRITE : (pick < 80) ? OP_READ : OP_BURST;
        pick = $urandom_range(0, 9);
        run_txn(op, rand_addr(), rand_byte(),
                (pick < 7) ? MISO_RANDOM : (pick < 8) ? MISO_ONES : MISO_ZEROS,
                $urandom_range(0, 3));
      end
    end
    settle();
  endtask

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_run = $urandom_range(20, 120);
    end
    stall_run--;
    stall_phase <= stall_phase + 3'd1;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PERIODIC: out_stall <= (stall_phase[1:0] == 2'd3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("unexpected result beat: %p", out_data);
      end else begin
        want_beat = expected_ticks.pop_front();
        if (beat_differs(want_beat, out_data)) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("beat mismatch: expected %p, actual %p", want_beat, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats pending", cycle_count,
               expected_ticks.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_link();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_ticks();
    test_register_write();
    test_register_read();
    test_back_to_back();
    test_burst_reset_address();
    test_burst_address_extremes();
    test_input_backpressure();
    test_random_traffic();
    settle();
    if (expected_ticks.size() != 0) begin
      fail_count++;
      $display("%0d expected beats never arrived", expected_ticks.size());
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
